/* rtl/rau_pkg.sv */
package rau_pkg;

    // operand word width, the ports stay 32 bits
    localparam int WORD_BITS = 32;
    localparam int IN_W      = 32;
    localparam int DEN_OUT_W = 31;
    localparam int MAG_W     = WORD_BITS;
    localparam int ACC_W     = 2 * WORD_BITS;
    localparam int CNT_W     = $clog2(ACC_W);

    // mode codes
    localparam logic [2:0] MODE_ADD   = 3'd0;
    localparam logic [2:0] MODE_SUB   = 3'd1;
    localparam logic [2:0] MODE_MUL   = 3'd2;
    localparam logic [2:0] MODE_DIV   = 3'd3;
    localparam logic [2:0] MODE_CMP   = 3'd4;
    localparam logic [2:0] MODE_NORM  = 3'd5;
    localparam logic [2:0] MODE_RECIP = 3'd6;
    localparam logic [2:0] MODE_BAD   = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_ADD,
        S_GINIT,
        S_GCD,
        S_DIVN,
        S_DINITD,
        S_DIVD,
        S_WB
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_ADD,
        OP_GINIT,
        OP_GSTEP,
        OP_DINITN,
        OP_DSTEP,
        OP_DINITD,
        OP_WRITE
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic is_cmp;
        logic gcd_done;
        logic div_last;
    } t_stat;

endpackage

/* rtl/rational_arithmetic_unit_top.sv */
// Rational arithmetic unit: adds, subtracts, multiplies, divides or compares
// two fractions, or normalises or inverts the first, returning the result
// reduced by the gcd with a positive denominator. One item is worked at a
// time; the input stalls from acceptance until the result is written to the
// output register, which may still wait on the far side while the next item
// is taken. The gcd works in binary steps, one shift or subtract a cycle,
// and a bit-serial divider then reduces numerator and denominator in turn;
// errors (zero denominator, zero divisor, mode seven) skip from the first
// multiply state straight to the write, and compare finishes after the
// sign-magnitude sum. Status 1 flags a zero denominator or divisor or mode
// seven, status 2 a reduced result that does not fit the word.
module rational_arithmetic_unit_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [2:0]                      i_mode,
    input  logic signed [rau_pkg::IN_W-1:0] i_a_num,
    input  logic signed [rau_pkg::IN_W-1:0] i_a_den,
    input  logic signed [rau_pkg::IN_W-1:0] i_b_num,
    input  logic signed [rau_pkg::IN_W-1:0] i_b_den,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [rau_pkg::IN_W-1:0] o_res_num,
    output logic [rau_pkg::DEN_OUT_W-1:0]   o_res_den,
    output logic                            o_less,
    output logic                            o_equal,
    output logic [1:0]                      o_status
);
    import rau_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // multiplier, gcd and divider datapath
    rau_dpath u_dpath (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_mode    (i_mode),
        .i_a_num   (i_a_num),
        .i_a_den   (i_a_den),
        .i_b_num   (i_b_num),
        .i_b_den   (i_b_den),
        .o_res_num (o_res_num),
        .o_res_den (o_res_den),
        .o_less    (o_less),
        .o_equal   (o_equal),
        .o_status  (o_status)
    );

endmodule

/* rtl/rau_ctrl.sv */
module rau_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  rau_pkg::t_stat i_stat,
    output rau_pkg::t_cmd  o_cmd
);
    import rau_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_MUL0;
            S_MUL0:   n_state = i_stat.err ? S_WB : S_MUL1;
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_ADD;
            S_ADD:    n_state = i_stat.is_cmp ? S_WB : S_GINIT;
            S_GINIT:  n_state = S_GCD;
            S_GCD:    if (i_stat.gcd_done) n_state = S_DIVN;
            S_DIVN:   if (i_stat.div_last) n_state = S_DINITD;
            S_DINITD: n_state = S_DIVD;
            S_DIVD:   if (i_stat.div_last) n_state = S_WB;
            S_WB:     if (!r_ovalid || !i_out_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath commands and handshake outputs
    always_comb begin
        o_cmd.op   = OP_NONE;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) o_cmd.op = OP_LOAD;
            end
            S_MUL0:   if (!i_stat.err) o_cmd.op = OP_MUL0;
            S_MUL1:   o_cmd.op = OP_MUL1;
            S_MUL2:   o_cmd.op = OP_MUL2;
            S_ADD:    o_cmd.op = OP_ADD;
            S_GINIT:  o_cmd.op = OP_GINIT;
            S_GCD:    o_cmd.op = i_stat.gcd_done ? OP_DINITN : OP_GSTEP;
            S_DIVN:   o_cmd.op = OP_DSTEP;
            S_DINITD: o_cmd.op = OP_DINITD;
            S_DIVD:   o_cmd.op = OP_DSTEP;
            S_WB:     if (!r_ovalid || !i_out_stall) o_cmd.op = OP_WRITE;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    // output valid: set on write, cleared when taken
    always_comb begin
        n_ovalid = r_ovalid;
        if (r_ovalid && !i_out_stall) n_ovalid = 1'b0;
        if (o_cmd.op == OP_WRITE) n_ovalid = 1'b1;
    end

    assign o_out_valid = r_ovalid;

endmodule

/* rtl/rau_dpath.sv */
module rau_dpath (
    input  logic                                  i_clk,
    input  rau_pkg::t_cmd                          i_cmd,
    output rau_pkg::t_stat                         o_stat,
    input  logic [2:0]                            i_mode,
    input  logic signed [rau_pkg::IN_W-1:0]       i_a_num,
    input  logic signed [rau_pkg::IN_W-1:0]       i_a_den,
    input  logic signed [rau_pkg::IN_W-1:0]       i_b_num,
    input  logic signed [rau_pkg::IN_W-1:0]       i_b_den,
    output logic signed [rau_pkg::IN_W-1:0]       o_res_num,
    output logic [rau_pkg::DEN_OUT_W-1:0]         o_res_den,
    output logic                                  o_less,
    output logic                                  o_equal,
    output logic [1:0]                            o_status
);
    import rau_pkg::*;

    localparam logic [MAG_W-1:0] ONE = MAG_W'(1);
    localparam logic [ACC_W-1:0] LIM = ACC_W'(1) << (WORD_BITS - 1);

    // sign and magnitude of the low word bits
    function automatic logic [MAG_W:0] sext(input logic [IN_W-1:0] raw);
        logic [MAG_W-1:0] v;
        v = raw[WORD_BITS-1:0];
        sext = v[MAG_W-1] ? {1'b1, (~v) + ONE} : {1'b0, v};
    endfunction

    // sign-magnitude add, zero is positive
    function automatic logic [ACC_W:0] smadd(input logic xs, input logic [ACC_W-1:0] xm,
                                             input logic ys, input logic [ACC_W-1:0] ym);
        logic             s;
        logic [ACC_W-1:0] m;
        if (xs == ys) begin
            m = xm + ym;
            s = xs;
        end else if (xm >= ym) begin
            m = xm - ym;
            s = xs;
        end else begin
            m = ym - xm;
            s = ys;
        end
        if (m == '0) s = 1'b0;
        smadd = {s, m};
    endfunction

    logic [2:0]       r_mode;
    logic             r_err;
    logic             r_an_s, r_ad_s, r_bn_s, r_bd_s;
    logic [MAG_W-1:0] r_an_m, r_ad_m, r_bn_m, r_bd_m;
    logic             r_x_s, r_y_s, r_d_s, r_n_s;
    logic [ACC_W-1:0] r_x_m, r_y_m, r_d_m, r_n_m;
    logic [ACC_W-1:0] r_u, r_v, r_g, r_rem, r_q, r_qn;
    logic [CNT_W-1:0] r_k, r_cnt;
    logic signed [IN_W-1:0]   r_res_num;
    logic [DEN_OUT_W-1:0]     r_res_den;
    logic             r_less, r_equal;
    logic [1:0]       r_status;

    logic [MAG_W:0]   an_sm, ad_sm, bn_sm, bd_sm;
    logic             load_err;
    logic [MAG_W-1:0] m_a, m_b;
    logic             m_sa, m_sb;
    logic [ACC_W-1:0] prod;
    logic             prod_s;
    logic [ACC_W:0]   sum;
    logic [ACC_W:0]   rs;
    logic             ge;
    logic [ACC_W-1:0] gval;
    logic             res_neg, ovf;
    logic [IN_W-1:0]  qn_w;

    // input decode and early error check
    always_comb begin
        an_sm = sext(i_a_num);
        ad_sm = sext(i_a_den);
        bn_sm = sext(i_b_num);
        bd_sm = sext(i_b_den);
        load_err = (i_mode == MODE_BAD) || (ad_sm[MAG_W-1:0] == '0)
            || ((i_mode <= MODE_CMP) && (bd_sm[MAG_W-1:0] == '0))
            || ((i_mode == MODE_DIV) && (bn_sm[MAG_W-1:0] == '0))
            || ((i_mode == MODE_RECIP) && (an_sm[MAG_W-1:0] == '0));
    end

    // shared multiplier operand select
    always_comb begin
        m_a = r_an_m; m_sa = r_an_s;
        m_b = r_bd_m; m_sb = r_bd_s;
        case (i_cmd.op)
            OP_MUL0: begin
                case (r_mode)
                    MODE_MUL:   begin m_b = r_bn_m; m_sb = r_bn_s; end
                    MODE_NORM:  begin m_b = ONE; m_sb = 1'b0; end
                    MODE_RECIP: begin
                        m_a = r_ad_m; m_sa = r_ad_s; m_b = ONE; m_sb = 1'b0;
                    end
                    default:    begin m_b = r_bd_m; m_sb = r_bd_s; end
                endcase
            end
            OP_MUL1: begin
                m_a = r_bn_m; m_sa = r_bn_s;
                m_b = r_ad_m; m_sb = r_ad_s;
            end
            default: begin
                m_a = r_ad_m; m_sa = r_ad_s;
                case (r_mode)
                    MODE_DIV:   begin m_b = r_bn_m; m_sb = r_bn_s; end
                    MODE_NORM:  begin m_b = ONE; m_sb = 1'b0; end
                    MODE_RECIP: begin
                        m_a = r_an_m; m_sa = r_an_s; m_b = ONE; m_sb = 1'b0;
                    end
                    default:    begin m_b = r_bd_m; m_sb = r_bd_s; end
                endcase
            end
        endcase
        prod   = ACC_W'(m_a) * ACC_W'(m_b);
        prod_s = (prod != '0) && (m_sa != m_sb);
    end

    // numerator sum, divider step, gcd result
    always_comb begin
        sum  = smadd(r_x_s, r_x_m, r_y_s, r_y_m);
        rs   = {r_rem, r_q[ACC_W-1]};
        ge   = rs >= {1'b0, r_g};
        gval = r_u << r_k;
    end

    // final reduction and range check
    always_comb begin
        res_neg = (r_qn != '0) && (r_n_s != r_d_s);
        ovf     = (r_q >= LIM) || (res_neg ? (r_qn > LIM) : (r_qn >= LIM));
        qn_w    = IN_W'(r_qn);
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_mode <= i_mode;
                r_err  <= load_err;
                {r_an_s, r_an_m} <= an_sm;
                {r_ad_s, r_ad_m} <= ad_sm;
                {r_bn_s, r_bn_m} <= bn_sm;
                {r_bd_s, r_bd_m} <= bd_sm;
            end
            OP_MUL0: begin
                r_x_m <= prod;
                r_x_s <= prod_s;
            end
            OP_MUL1: begin
                r_y_m <= prod;
                r_y_s <= (prod != '0) &&
                         (prod_s ^ ((r_mode == MODE_SUB) || (r_mode == MODE_CMP)));
            end
            OP_MUL2: begin
                r_d_m <= prod;
                r_d_s <= prod_s;
            end
            OP_ADD: begin
                if ((r_mode == MODE_ADD) || (r_mode == MODE_SUB) || (r_mode == MODE_CMP))
                    {r_n_s, r_n_m} <= sum;
                else
                    {r_n_s, r_n_m} <= {r_x_s, r_x_m};
            end
            OP_GINIT: begin
                r_k <= '0;
                if (r_n_m == '0) begin
                    r_u <= r_d_m;
                    r_v <= '0;
                end else begin
                    r_u <= r_n_m;
                    r_v <= r_d_m;
                end
            end
            OP_GSTEP: begin
                // binary gcd, one step a cycle
                if (!r_u[0] && !r_v[0]) begin
                    r_u <= r_u >> 1;
                    r_v <= r_v >> 1;
                    r_k <= r_k + CNT_W'(1);
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u > r_v) begin
                    r_u <= r_v;
                    r_v <= r_u - r_v;
                end else begin
                    r_v <= r_v - r_u;
                end
            end
            OP_DINITN: begin
                r_g   <= gval;
                r_q   <= r_n_m;
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_DINITD: begin
                r_qn  <= r_q;
                r_q   <= r_d_m;
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_DSTEP: begin
                // restoring division, one quotient bit a cycle
                r_rem <= ge ? ACC_W'(rs - {1'b0, r_g}) : rs[ACC_W-1:0];
                r_q   <= {r_q[ACC_W-2:0], ge};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            OP_WRITE: begin
                r_res_num <= '0;
                r_res_den <= '0;
                r_less    <= 1'b0;
                r_equal   <= 1'b0;
                if (r_err) begin
                    r_status <= ST_ZERO;
                end else if (r_mode == MODE_CMP) begin
                    r_status <= ST_OK;
                    r_equal  <= (r_n_m == '0);
                    r_less   <= (r_n_m != '0) && (r_n_s != (r_ad_s != r_bd_s));
                end else if (ovf) begin
                    r_status <= ST_OVF;
                end else begin
                    r_status  <= ST_OK;
                    r_res_num <= res_neg ? (IN_W'(0) - qn_w) : qn_w;
                    r_res_den <= DEN_OUT_W'(r_q);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stat.err      = r_err;
    assign o_stat.is_cmp   = (r_mode == MODE_CMP);
    assign o_stat.gcd_done = (r_v == '0);
    assign o_stat.div_last = (r_cnt == CNT_W'(ACC_W - 1));

    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_less    = r_less;
    assign o_equal   = r_equal;
    assign o_status  = r_status;

endmodule

/* tb/rau_checker.sv */
`timescale 1ns / 1ps

module rau_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [2:0]        i_mode,
    input  logic signed [31:0] i_a_num,
    input  logic signed [31:0] i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic signed [31:0] i_b_den,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic signed [31:0] i_res_num,
    input  logic [30:0]       i_res_den,
    input  logic              i_less,
    input  logic              i_equal,
    input  logic [1:0]        i_status,
    output int                o_fail_count,
    output int                o_pending
);
    import rau_pkg::*;

    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic               less;
        logic               equal;
        logic [1:0]         status;
    } t_fraction_result;

    t_fraction_result awaited_results[$];

    // sign-extend the low WORD_BITS bits into a wide signed value
    function automatic logic signed [127:0] widen(input logic [31:0] raw);
        logic signed [127:0] v;
        v = 128'(raw[WORD_BITS-1:0]);
        if (raw[WORD_BITS-1])
            v = v - (128'sd1 <<< WORD_BITS);
        return v;
    endfunction

    function automatic logic [127:0] gcd_of(input logic [127:0] x, input logic [127:0] y);
        logic [127:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // reduce n/d, make the denominator positive and range check
    function automatic t_fraction_result reduce_fraction(input logic signed [127:0] n,
                                                         input logic signed [127:0] d);
        t_fraction_result r;
        logic [127:0] nm, dm, g, lim;
        logic neg;
        r = '0;
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        g = gcd_of(nm, dm);
        nm = nm / g;
        dm = dm / g;
        neg = (nm != 0) && ((n < 0) != (d < 0));
        lim = 128'd1 << (WORD_BITS - 1);
        if (dm >= lim || (neg ? nm > lim : nm >= lim)) begin
            r.status = ST_OVF;
        end else begin
            r.num = neg ? 32'(-nm) : 32'(nm);
            r.den = 31'(dm);
            r.status = ST_OK;
        end
        return r;
    endfunction

    function automatic t_fraction_result predict_fraction(input logic [2:0] mode,
            input logic [31:0] an_raw, input logic [31:0] ad_raw,
            input logic [31:0] bn_raw, input logic [31:0] bd_raw);
        t_fraction_result r;
        logic signed [127:0] an, ad, bn, bd, diff;
        r = '0;
        an = widen(an_raw);
        ad = widen(ad_raw);
        bn = widen(bn_raw);
        bd = widen(bd_raw);
        if (mode == MODE_BAD || ad == 0 || (mode <= MODE_CMP && bd == 0)) begin
            r.status = ST_ZERO;
            return r;
        end
        case (mode)
            MODE_ADD: r = reduce_fraction(an * bd + bn * ad, ad * bd);
            MODE_SUB: r = reduce_fraction(an * bd - bn * ad, ad * bd);
            MODE_MUL: r = reduce_fraction(an * bn, ad * bd);
            MODE_DIV: begin
                if (bn == 0) r.status = ST_ZERO;
                else r = reduce_fraction(an * bd, ad * bn);
            end
            MODE_CMP: begin
                diff = an * bd - bn * ad;
                if ((ad < 0) != (bd < 0)) diff = -diff;
                r.equal = (diff == 0);
                r.less  = (diff < 0);
            end
            MODE_NORM: r = reduce_fraction(an, ad);
            default: begin
                if (an == 0) r.status = ST_ZERO;
                else r = reduce_fraction(ad, an);
            end
        endcase
        return r;
    endfunction

    assign o_pending = awaited_results.size();

    always @(posedge i_clk) begin
        t_fraction_result got, want;
        if (i_rst_n && i_in_valid && !i_in_stall)
            awaited_results.push_back(predict_fraction(i_mode, i_a_num, i_a_den,
                                                       i_b_num, i_b_den));
        // compare each accepted result with the oldest expectation
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            got = '{i_res_num, i_res_den, i_less, i_equal, i_status};
            if (awaited_results.size() == 0) begin
                o_fail_count <= o_fail_count + 1;
                if (o_fail_count < 10)
                    $display("unexpected result num=%0d den=%0d", i_res_num, i_res_den);
            end else begin
                want = awaited_results.pop_front();
                if (got !== want) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display({"mismatch: exp num=%0d den=%0d lt=%b eq=%b st=%0d",
                                  " | got num=%0d den=%0d lt=%b eq=%b st=%0d"},
                                 want.num, want.den, want.less, want.equal, want.status,
                                 got.num, got.den, got.less, got.equal, got.status);
                end
            end
        end
    end

    initial o_fail_count = 0;

endmodule

/* tb/tb_rational_arithmetic_unit_top.sv */
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit_top;
    import rau_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [2:0]        mode = MODE_ADD;
    logic signed [31:0] a_num = '0, a_den = 32'sd1, b_num = '0, b_den = 32'sd1;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic signed [31:0] res_num;
    logic [30:0]       res_den;
    logic              less, equal;
    logic [1:0]        status;
    int                fail_count, pending;
    int                sender_idle_pct = 0, receiver_stall_pct = 0;
    longint            cycle_count = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    rational_arithmetic_unit_top uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_mode(mode), .i_a_num(a_num), .i_a_den(a_den), .i_b_num(b_num),
        .i_b_den(b_den), .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_res_num(res_num), .o_res_den(res_den), .o_less(less), .o_equal(equal),
        .o_status(status)
    );

    rau_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_mode(mode), .i_a_num(a_num), .i_a_den(a_den), .i_b_num(b_num),
        .i_b_den(b_den), .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_res_num(res_num), .i_res_den(res_den), .i_less(less), .i_equal(equal),
        .i_status(status), .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stalls at random
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < receiver_stall_pct);

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // random operand word with a bias to extremes and small values
    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(20)) - 10);
            3: return 32'(int'($urandom_range(2000)) - 1000);
            4: return 32'h0;
            5: return $urandom & 32'h0000_ffff;
            default: return $urandom;
        endcase
    endfunction

    // hold the item until accepted, with random idle cycles first
    task automatic send_item(input logic [2:0] m, input logic [31:0] an,
                             input logic [31:0] ad, input logic [31:0] bn,
                             input logic [31:0] bd);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        a_num <= an;
        a_den <= ad;
        b_num <= bn;
        b_den <= bd;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_random(input int count);
        logic [31:0] ad, bd;
        repeat (count) begin
            // mostly nonzero denominators so the arithmetic is reached
            ad = pick_word();
            bd = pick_word();
            if (ad == 0 && $urandom_range(3) != 0) ad = 32'd1;
            if (bd == 0 && $urandom_range(3) != 0) bd = 32'hffff_fffd;
            send_item(3'($urandom_range(7)), pick_word(), ad, pick_word(), bd);
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed items
        send_item(MODE_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
        send_item(MODE_SUB, 32'sd1, 32'sd2, 32'sd1, 32'sd2);
        send_item(MODE_MUL, 32'h8000_0000, 32'sd1, 32'h8000_0000, 32'sd1);
        send_item(MODE_DIV, 32'sd3, 32'sd4, 32'sd0, 32'sd5);
        send_item(MODE_DIV, 32'sd3, -32'sd4, -32'sd6, 32'sd5);
        send_item(MODE_CMP, 32'sd1, 32'sd3, 32'sd1, 32'sd2);
        send_item(MODE_CMP, 32'sd2, -32'sd4, -32'sd1, 32'sd2);
        send_item(MODE_CMP, 32'sd5, -32'sd1, 32'sd1, 32'sd1);
        send_item(MODE_NORM, 32'sd6, -32'sd4, 32'sd0, 32'sd0);
        send_item(MODE_NORM, 32'sd0, -32'sd7, 32'sd0, 32'sd1);
        send_item(MODE_NORM, 32'h8000_0000, 32'hffff_ffff, 32'sd0, 32'sd1);
        send_item(MODE_NORM, 32'sd1, 32'h8000_0000, 32'sd0, 32'sd1);
        send_item(MODE_RECIP, 32'sd0, 32'sd3, 32'sd1, 32'sd1);
        send_item(MODE_RECIP, -32'sd3, 32'h7fff_ffff, 32'sd1, 32'sd1);
        send_item(MODE_ADD, 32'sd1, 32'sd0, 32'sd1, 32'sd1);
        send_item(MODE_MUL, 32'sd1, 32'sd1, 32'sd1, 32'sd0);
        send_item(MODE_BAD, 32'sd1, 32'sd1, 32'sd1, 32'sd1);
        send_item(MODE_ADD, 32'h7fff_ffff, 32'sd1, 32'h7fff_ffff, 32'sd1);
        send_item(MODE_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000);
        send_item(MODE_CMP, 32'sd0, 32'h8000_0000, 32'sd0, 32'sd9);
        // random phases with different idling
        send_random(150);
        sender_idle_pct = 58;
        send_random(150);
        sender_idle_pct = 0;
        receiver_stall_pct = 58;
        send_random(150);
        sender_idle_pct = 25;
        receiver_stall_pct = 25;
        send_random(150);
        in_valid <= 1'b0;
        // drain
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/rau_pkg.sv
rtl/rau_ctrl.sv
rtl/rau_dpath.sv
rtl/rational_arithmetic_unit_top.sv
tb/rau_checker.sv
tb/tb_rational_arithmetic_unit_top.sv
